[rtl/core/cle_pkg.sv]
`default_nettype none

package cle_pkg;

    // Table geometry
    localparam int unsigned SLOTS    = 16;
    localparam int unsigned SLOT_W   = $clog2(SLOTS);
    localparam int unsigned LINK_W   = $clog2(SLOTS + 1);
    localparam int unsigned VAL_W    = 16;
    localparam int unsigned ACT_W    = 2;
    localparam int unsigned STAT_W   = 3;
    localparam int unsigned PC_W     = 4;

    localparam logic [LINK_W-1:0] END_MARK = LINK_W'(SLOTS);

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [LINK_W-1:0] t_link;
    typedef logic [VAL_W-1:0]  t_value;
    typedef logic [PC_W-1:0]   t_pc;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_FIND   = 2'd3
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_NO_SPACE  = 3'd2,
        ST_BAD_INDEX = 3'd3,
        ST_BAD_VALUE = 3'd4
    } t_status;

    // Datapath operations of one microcode step
    typedef enum logic [3:0] {
        U_NOP,
        U_LATCH,
        U_RD_SLOT,
        U_CHECK,
        U_SCAN_INIT,
        U_SCAN,
        U_LINK_P,
        U_RD_P,
        U_LOAD_N,
        U_LINK_W1,
        U_LINK_W2,
        U_RM_W1,
        U_RM_W2,
        U_FIND_DONE,
        U_EMIT
    } t_uop;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_FIRE,
        C_ERR,
        C_REMOVE,
        C_SCAN_MORE,
        C_FIND,
        C_NOFREE,
        C_OUT_FREE
    } t_cond;

    // Control word: on a true condition jump to target, else hold or step on
    typedef struct packed {
        t_uop  uop;
        t_cond cond;
        logic  hold;
        t_pc   target;
    } t_uword;

    // Program step addresses
    localparam t_pc PC_IDLE      = 4'd0;
    localparam t_pc PC_RDSLOT    = 4'd1;
    localparam t_pc PC_CHECK     = 4'd2;
    localparam t_pc PC_DISPATCH  = 4'd3;
    localparam t_pc PC_SCAN      = 4'd4;
    localparam t_pc PC_SCAN_LAST = 4'd5;
    localparam t_pc PC_LINK_P    = 4'd6;
    localparam t_pc PC_LINK_RD   = 4'd7;
    localparam t_pc PC_LINK_N    = 4'd8;
    localparam t_pc PC_LINK_W1   = 4'd9;
    localparam t_pc PC_LINK_W2   = 4'd10;
    localparam t_pc PC_RM_W1     = 4'd11;
    localparam t_pc PC_RM_W2     = 4'd12;
    localparam t_pc PC_FIND_DONE = 4'd13;
    localparam t_pc PC_EMIT      = 4'd14;

    // Microcode ROM
    function automatic t_uword ucode_rom(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_IDLE:      w = '{uop: U_LATCH,     cond: C_FIRE,      hold: 1'b1,
                                target: PC_RDSLOT};
            PC_RDSLOT:    w = '{uop: U_RD_SLOT,   cond: C_NEVER,     hold: 1'b0,
                                target: PC_IDLE};
            PC_CHECK:     w = '{uop: U_CHECK,     cond: C_ERR,       hold: 1'b0,
                                target: PC_EMIT};
            PC_DISPATCH:  w = '{uop: U_SCAN_INIT, cond: C_REMOVE,    hold: 1'b0,
                                target: PC_RM_W1};
            PC_SCAN:      w = '{uop: U_SCAN,      cond: C_SCAN_MORE, hold: 1'b0,
                                target: PC_SCAN};
            PC_SCAN_LAST: w = '{uop: U_NOP,       cond: C_FIND,      hold: 1'b0,
                                target: PC_FIND_DONE};
            PC_LINK_P:    w = '{uop: U_LINK_P,    cond: C_NOFREE,    hold: 1'b0,
                                target: PC_EMIT};
            PC_LINK_RD:   w = '{uop: U_RD_P,      cond: C_NEVER,     hold: 1'b0,
                                target: PC_IDLE};
            PC_LINK_N:    w = '{uop: U_LOAD_N,    cond: C_NEVER,     hold: 1'b0,
                                target: PC_IDLE};
            PC_LINK_W1:   w = '{uop: U_LINK_W1,   cond: C_NEVER,     hold: 1'b0,
                                target: PC_IDLE};
            PC_LINK_W2:   w = '{uop: U_LINK_W2,   cond: C_ALWAYS,    hold: 1'b0,
                                target: PC_EMIT};
            PC_RM_W1:     w = '{uop: U_RM_W1,     cond: C_NEVER,     hold: 1'b0,
                                target: PC_IDLE};
            PC_RM_W2:     w = '{uop: U_RM_W2,     cond: C_ALWAYS,    hold: 1'b0,
                                target: PC_EMIT};
            PC_FIND_DONE: w = '{uop: U_FIND_DONE, cond: C_NEVER,     hold: 1'b0,
                                target: PC_IDLE};
            PC_EMIT:      w = '{uop: U_EMIT,      cond: C_OUT_FREE,  hold: 1'b1,
                                target: PC_IDLE};
            default:      w = '{uop: U_NOP,       cond: C_ALWAYS,    hold: 1'b0,
                                target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/core/cle_in_if.sv]
`default_nettype none

// Request word channel
interface cle_in_if;
    import cle_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic [VAL_W-1:0]    value;
    logic [SLOT_W-1:0]   slot;

    modport source (output valid, output action, output value, output slot, input ready);
    modport sink   (input valid, input action, input value, input slot, output ready);
endinterface

`default_nettype wire

[rtl/core/cle_out_if.sv]
`default_nettype none

// Result word channel
interface cle_out_if;
    import cle_pkg::*;

    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   result_slot;
    logic [STAT_W-1:0]   status;

    modport source (output valid, output result_slot, output status, input ready);
    modport sink   (input valid, input result_slot, input status, output ready);
endinterface

`default_nettype wire

[rtl/core/cle_ram.sv]
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module cle_ram #(
    parameter int unsigned W     = 16,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/cursor_linked_list_engine.sv]
`default_nettype none

// Doubly linked list kept in a 16-slot table (slot 0 is the head sentinel), driven by a
// small microcoded sequencer. One request word is taken at a time; ready is high only
// while the sequencer sits in its idle step. Remove goes straight to its writes, a
// request rejected by its index or value check goes straight to its result, and append,
// insert and find first scan the table, one entry per cycle through the single read port
// of the slot RAMs. The result sits in an output register, so the next request is taken
// while a result waits. Reset needs no clearing pass: per-entry valid bits make unwritten
// entries read as their reset contents.
module cursor_linked_list_engine (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cle_in_if.sink     i_in,
    cle_out_if.source  o_out
);
    import cle_pkg::*;

    // Sequencer
    t_pc     r_pc;
    t_pc     n_pc;
    t_uword  uw;
    logic    cond_true;

    // Latched request
    t_action r_act;
    t_value  r_val;
    t_slot   r_slot;

    // Working registers
    t_link   r_p;
    t_link   r_n;
    t_slot   r_idx;
    t_slot   r_cmp_idx;
    logic    r_cmp_vld;
    t_slot   r_free;
    t_slot   r_tail;
    t_slot   r_match;
    logic    r_free_hit;
    logic    r_tail_hit;
    logic    r_match_hit;
    t_slot   r_res;
    t_status r_st;

    // Output register
    logic    r_out_vld;
    t_slot   r_out_res;
    t_status r_out_st;

    // Store valid bits and read-side bookkeeping
    logic [SLOTS-1:0] r_vv;
    logic [SLOTS-1:0] r_nv;
    logic [SLOTS-1:0] r_pv;
    t_slot   r_raddr;
    logic    r_rd_vv;
    logic    r_rd_nv;
    logic    r_rd_pv;

    // RAM ports
    t_slot   raddr;
    t_value  ram_val;
    t_link   ram_next;
    t_link   ram_prev;
    logic    val_we;
    t_slot   val_waddr;
    t_value  val_wdata;
    logic    next_we;
    t_slot   next_waddr;
    t_link   next_wdata;
    logic    prev_we;
    t_slot   prev_waddr;
    t_link   prev_wdata;

    // Read data with reset contents for never-written entries
    t_value  rd_val;
    t_link   rd_next;
    t_link   rd_prev;
    t_link   link_rst;

    logic    in_fire;
    logic    out_free;
    logic    slot_used;
    logic    chk_err;
    t_status chk_st;
    logic    scan_used;

    assign uw       = ucode_rom(r_pc);
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_vld || o_out.ready;

    assign i_in.ready        = (r_pc == PC_IDLE) && i_rst_n;
    assign o_out.valid       = r_out_vld;
    assign o_out.result_slot = r_out_res;
    assign o_out.status      = r_out_st;

    assign link_rst = (r_raddr == '0) ? END_MARK : '0;
    assign rd_val   = r_rd_vv ? ram_val  : '0;
    assign rd_next  = r_rd_nv ? ram_next : link_rst;
    assign rd_prev  = r_rd_pv ? ram_prev : link_rst;

    // Slot RAMs
    cle_ram #(.W(VAL_W), .DEPTH(SLOTS)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_raddr (raddr),
        .o_rdata (ram_val)
    );

    cle_ram #(.W(LINK_W), .DEPTH(SLOTS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_raddr (raddr),
        .o_rdata (ram_next)
    );

    cle_ram #(.W(LINK_W), .DEPTH(SLOTS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_raddr (raddr),
        .o_rdata (ram_prev)
    );

    // Jump condition
    always_comb begin
        unique case (uw.cond)
            C_NEVER:     cond_true = 1'b0;
            C_ALWAYS:    cond_true = 1'b1;
            C_FIRE:      cond_true = in_fire;
            C_ERR:       cond_true = chk_err;
            C_REMOVE:    cond_true = (r_act == ACT_REMOVE);
            C_SCAN_MORE: cond_true = (r_idx != SLOT_W'(SLOTS - 1));
            C_FIND:      cond_true = (r_act == ACT_FIND);
            C_NOFREE:    cond_true = !r_free_hit;
            C_OUT_FREE:  cond_true = out_free;
            default:     cond_true = 1'b0;
        endcase
    end

    // Next step
    always_comb begin
        if (cond_true) begin
            n_pc = uw.target;
        end else if (uw.hold) begin
            n_pc = r_pc;
        end else begin
            n_pc = t_pc'(r_pc + 1'b1);
        end
    end

    // Request checks on the addressed slot
    always_comb begin
        slot_used = (r_slot == '0) || (rd_val != '0);
        chk_err   = 1'b0;
        chk_st    = ST_OK;
        unique case (r_act)
            ACT_APPEND, ACT_FIND: begin
                if (r_val == '0) begin
                    chk_err = 1'b1;
                    chk_st  = ST_BAD_VALUE;
                end
            end
            ACT_INSERT: begin
                if (!slot_used) begin
                    chk_err = 1'b1;
                    chk_st  = ST_BAD_INDEX;
                end else if (r_val == '0) begin
                    chk_err = 1'b1;
                    chk_st  = ST_BAD_VALUE;
                end
            end
            ACT_REMOVE: begin
                if ((r_slot == '0) || (rd_val == '0)) begin
                    chk_err = 1'b1;
                    chk_st  = ST_BAD_INDEX;
                end
            end
            default: begin
                chk_err = 1'b0;
            end
        endcase
    end

    // Read address
    always_comb begin
        unique case (uw.uop)
            U_SCAN:  raddr = r_idx;
            U_RD_P:  raddr = r_p[SLOT_W-1:0];
            default: raddr = r_slot;
        endcase
    end

    // Store write ports
    always_comb begin
        val_we     = 1'b0;
        val_waddr  = r_slot;
        val_wdata  = '0;
        next_we    = 1'b0;
        next_waddr = r_slot;
        next_wdata = '0;
        prev_we    = 1'b0;
        prev_waddr = r_slot;
        prev_wdata = '0;
        unique case (uw.uop)
            U_LINK_W1: begin
                val_we     = 1'b1;
                val_waddr  = r_free;
                val_wdata  = r_val;
                next_we    = 1'b1;
                next_waddr = r_free;
                next_wdata = r_n;
                prev_we    = 1'b1;
                prev_waddr = r_free;
                prev_wdata = r_p;
            end
            U_LINK_W2: begin
                next_we    = 1'b1;
                next_waddr = r_p[SLOT_W-1:0];
                next_wdata = {1'b0, r_free};
                prev_we    = (r_n < END_MARK);
                prev_waddr = r_n[SLOT_W-1:0];
                prev_wdata = {1'b0, r_free};
            end
            U_RM_W1: begin
                val_we     = 1'b1;
                next_we    = (r_p < END_MARK);
                next_waddr = r_p[SLOT_W-1:0];
                next_wdata = r_n;
                prev_we    = (r_n < END_MARK);
                prev_waddr = r_n[SLOT_W-1:0];
                prev_wdata = r_p;
            end
            U_RM_W2: begin
                next_we    = 1'b1;
                prev_we    = 1'b1;
            end
            default: begin
                val_we     = 1'b0;
            end
        endcase
    end

    // Control state: step counter, valid bits, output valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= PC_IDLE;
            r_out_vld <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_vv      <= '0;
            r_nv      <= '0;
            r_pv      <= '0;
        end else begin
            r_pc      <= n_pc;
            r_cmp_vld <= (uw.uop == U_SCAN);
            if (val_we) begin
                r_vv[val_waddr] <= 1'b1;
            end
            if (next_we) begin
                r_nv[next_waddr] <= 1'b1;
            end
            if (prev_we) begin
                r_pv[prev_waddr] <= 1'b1;
            end
            // new word loaded, else hold until taken
            r_out_vld <= ((uw.uop == U_EMIT) && out_free) || (r_out_vld && !o_out.ready);
        end
    end

    // Read-side bookkeeping follows the RAM read register
    always_ff @(posedge i_clk) begin
        r_raddr <= raddr;
        r_rd_vv <= r_vv[raddr];
        r_rd_nv <= r_nv[raddr];
        r_rd_pv <= r_pv[raddr];
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx;
        unique case (uw.uop)
            U_LATCH: begin
                if (in_fire) begin
                    r_act  <= t_action'(i_in.action);
                    r_val  <= i_in.value;
                    r_slot <= i_in.slot;
                end
            end
            U_CHECK: begin
                r_p <= rd_prev;
                r_n <= rd_next;
                if (chk_err) begin
                    r_res <= '0;
                    r_st  <= chk_st;
                end
            end
            U_SCAN_INIT: begin
                r_idx <= '0;
            end
            U_SCAN: begin
                r_idx <= t_slot'(r_idx + 1'b1);
            end
            U_LINK_P: begin
                r_p <= (r_act == ACT_APPEND) ? {1'b0, r_tail} : {1'b0, r_slot};
                if (!r_free_hit) begin
                    r_res <= '0;
                    r_st  <= ST_NO_SPACE;
                end
            end
            U_LOAD_N: begin
                r_n <= rd_next;
            end
            U_LINK_W2: begin
                r_res <= r_free;
                r_st  <= ST_OK;
            end
            U_RM_W2: begin
                r_res <= r_slot;
                r_st  <= ST_OK;
            end
            U_FIND_DONE: begin
                r_res <= r_match;
                r_st  <= r_match_hit ? ST_OK : ST_NOT_FOUND;
            end
            U_EMIT: begin
                if (out_free) begin
                    r_out_res <= r_res;
                    r_out_st  <= r_st;
                end
            end
            default: begin
            end
        endcase
    end

    // Scan compare: lowest free slot, tail and lowest match
    assign scan_used = (r_cmp_idx == '0) || (rd_val != '0);

    always_ff @(posedge i_clk) begin
        if (uw.uop == U_SCAN_INIT) begin
            r_free_hit  <= 1'b0;
            r_tail_hit  <= 1'b0;
            r_match_hit <= 1'b0;
            r_free      <= '0;
            r_tail      <= '0;
            r_match     <= '0;
        end else if (r_cmp_vld) begin
            if (!r_free_hit && (r_cmp_idx != '0) && (rd_val == '0)) begin
                r_free_hit <= 1'b1;
                r_free     <= r_cmp_idx;
            end
            if (!r_tail_hit && scan_used && (rd_next == END_MARK)) begin
                r_tail_hit <= 1'b1;
                r_tail     <= r_cmp_idx;
            end
            if (!r_match_hit && (r_cmp_idx != '0) && (rd_val == r_val)) begin
                r_match_hit <= 1'b1;
                r_match     <= r_cmp_idx;
            end
        end
    end

endmodule

`default_nettype wire

[tb/cursor_linked_list_engine_test.sv]
`default_nettype none

module cursor_linked_list_engine_test;
    import cle_pkg::*;

    localparam int unsigned WDOG_LIMIT  = 5000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned PHASE_ITEMS = 220;
    localparam int unsigned PHASES      = 8;
    localparam int unsigned DIR_ROWS    = 23;
    // longest request is a full scan plus linking, with margin
    localparam int unsigned TAIL_CYCLES = 2 * SLOTS + 24;

    typedef enum int unsigned {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SNK,
        IDLE_BOTH
    } t_idle;

    typedef struct packed {
        t_slot   slot;
        t_status st;
    } t_result;

    // one row of the directed table; typed rows carry their own expectation
    typedef struct packed {
        t_action    act;
        t_value     value;
        t_slot      slot;
        logic [4:0] reps;
        logic       typed;
        t_slot      exp_slot;
        t_status    exp_st;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cle_in_if  req_if ();
    cle_out_if rsp_if ();

    cursor_linked_list_engine i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copy of the slot table
    t_value list_val  [SLOTS];
    t_link  list_next [SLOTS];
    t_link  list_prev [SLOTS];

    t_result     pending_results [$];
    int unsigned err_count   = 0;
    int unsigned src_pct     = 0;
    int unsigned snk_pct     = 0;
    bit          hold_req    = 1'b0;
    bit          fill_mode   = 1'b1;

    t_row directed_rows [DIR_ROWS] = '{
        '{ACT_FIND,   16'h1234, 4'd0,  5'd1,  1'b1, 4'd0, ST_NOT_FOUND},
        '{ACT_APPEND, 16'h0000, 4'd0,  5'd1,  1'b1, 4'd0, ST_BAD_VALUE},
        '{ACT_FIND,   16'h0000, 4'd0,  5'd1,  1'b1, 4'd0, ST_BAD_VALUE},
        '{ACT_INSERT, 16'h0001, 4'd5,  5'd1,  1'b1, 4'd0, ST_BAD_INDEX},
        // free predecessor wins over value zero
        '{ACT_INSERT, 16'h0000, 4'd15, 5'd1,  1'b1, 4'd0, ST_BAD_INDEX},
        '{ACT_INSERT, 16'h0000, 4'd0,  5'd1,  1'b1, 4'd0, ST_BAD_VALUE},
        '{ACT_REMOVE, 16'h0000, 4'd0,  5'd1,  1'b1, 4'd0, ST_BAD_INDEX},
        '{ACT_REMOVE, 16'hFFFF, 4'd15, 5'd1,  1'b1, 4'd0, ST_BAD_INDEX},
        '{ACT_APPEND, 16'hFFFF, 4'd0,  5'd1,  1'b1, 4'd1, ST_OK},
        '{ACT_APPEND, 16'h0001, 4'd15, 5'd1,  1'b1, 4'd2, ST_OK},
        '{ACT_INSERT, 16'h8000, 4'd1,  5'd1,  1'b1, 4'd3, ST_OK},
        '{ACT_FIND,   16'hFFFF, 4'd0,  5'd1,  1'b1, 4'd1, ST_OK},
        '{ACT_REMOVE, 16'h0000, 4'd2,  5'd1,  1'b1, 4'd2, ST_OK},
        '{ACT_INSERT, 16'h5555, 4'd2,  5'd1,  1'b1, 4'd0, ST_BAD_INDEX},
        // fill the rest of the table
        '{ACT_APPEND, 16'h00AA, 4'd0,  5'd13, 1'b0, 4'd0, ST_OK},
        '{ACT_APPEND, 16'h7777, 4'd0,  5'd1,  1'b1, 4'd0, ST_NO_SPACE},
        '{ACT_INSERT, 16'h7777, 4'd0,  5'd1,  1'b1, 4'd0, ST_NO_SPACE},
        '{ACT_FIND,   16'h00AA, 4'd0,  5'd1,  1'b0, 4'd0, ST_OK},
        '{ACT_REMOVE, 16'h0000, 4'd1,  5'd1,  1'b1, 4'd1, ST_OK},
        '{ACT_INSERT, 16'hAAAA, 4'd3,  5'd1,  1'b0, 4'd0, ST_OK},
        '{ACT_REMOVE, 16'h0000, 4'd15, 5'd1,  1'b0, 4'd0, ST_OK},
        '{ACT_APPEND, 16'h1357, 4'd0,  5'd1,  1'b0, 4'd0, ST_OK},
        '{ACT_FIND,   16'h0001, 4'd0,  5'd1,  1'b1, 4'd0, ST_NOT_FOUND}
    };

    function automatic void list_clear();
        for (int i = 0; i < SLOTS; i++) begin
            list_val[i]  = '0;
            list_next[i] = '0;
            list_prev[i] = '0;
        end
        list_next[0] = END_MARK;
        list_prev[0] = END_MARK;
    endfunction

    function automatic bit slot_busy(int unsigned s);
        if (s >= SLOTS)
            return 1'b0;
        if (s == 0)
            return 1'b1;
        return list_val[s] != '0;
    endfunction

    function automatic int unsigned first_free();
        for (int unsigned i = 1; i < SLOTS; i++)
            if (list_val[i] == '0)
                return i;
        return 0;
    endfunction

    function automatic int unsigned used_count();
        int unsigned c;
        c = 0;
        for (int unsigned i = 1; i < SLOTS; i++)
            if (list_val[i] != '0)
                c++;
        return c;
    endfunction

    // link slot j in after slot p; writes toward the end marker are dropped
    function automatic void splice_after(int unsigned p, int unsigned j, t_value v);
        t_link n;
        n = list_next[p];
        list_next[j] = n;
        if (n < SLOTS)
            list_prev[n[SLOT_W-1:0]] = t_link'(j);
        list_next[p] = t_link'(j);
        list_prev[j] = t_link'(p);
        list_val[j]  = v;
    endfunction

    // Expected answer of one request word, updating the shadow table
    function automatic t_result list_predict(t_action a, t_value v, t_slot s);
        t_result     r;
        int unsigned j;
        int unsigned p;
        t_link       lp;
        t_link       ln;
        r.slot = '0;
        r.st   = ST_OK;
        case (a)
            ACT_APPEND: begin
                j = first_free();
                if (v == '0) begin
                    r.st = ST_BAD_VALUE;
                end else if (j == 0) begin
                    r.st = ST_NO_SPACE;
                end else begin
                    // tail is the first used slot ending the list, else the head
                    p = 0;
                    for (int unsigned i = 0; i < SLOTS; i++)
                        if (slot_busy(i) && list_next[i] == END_MARK) begin
                            p = i;
                            break;
                        end
                    splice_after(p, j, v);
                    r.slot = t_slot'(j);
                end
            end
            ACT_INSERT: begin
                j = first_free();
                if (!slot_busy(s)) begin
                    r.st = ST_BAD_INDEX;
                end else if (v == '0) begin
                    r.st = ST_BAD_VALUE;
                end else if (j == 0) begin
                    r.st = ST_NO_SPACE;
                end else begin
                    splice_after(s, j, v);
                    r.slot = t_slot'(j);
                end
            end
            ACT_REMOVE: begin
                if (s == '0 || !slot_busy(s)) begin
                    r.st = ST_BAD_INDEX;
                end else begin
                    lp = list_prev[s];
                    ln = list_next[s];
                    if (lp < SLOTS)
                        list_next[lp[SLOT_W-1:0]] = ln;
                    if (ln < SLOTS)
                        list_prev[ln[SLOT_W-1:0]] = lp;
                    list_val[s]  = '0;
                    list_next[s] = '0;
                    list_prev[s] = '0;
                    r.slot = s;
                end
            end
            default: begin
                if (v == '0) begin
                    r.st = ST_BAD_VALUE;
                end else begin
                    r.st = ST_NOT_FOUND;
                    for (int unsigned i = 1; i < SLOTS; i++)
                        if (list_val[i] == v) begin
                            r.slot = t_slot'(i);
                            r.st   = ST_OK;
                            break;
                        end
                end
            end
        endcase
        return r;
    endfunction

    // random slot in use; the head counts only when asked for
    function automatic t_slot pick_used(bit with_head);
        int unsigned k;
        int unsigned idx;
        k   = used_count() + (with_head ? 1 : 0);
        idx = $urandom_range(k - 1);
        for (int unsigned i = (with_head ? 0 : 1); i < SLOTS; i++)
            if (slot_busy(i)) begin
                if (idx == 0)
                    return t_slot'(i);
                idx--;
            end
        return '0;
    endfunction

    // Random request word, swinging the table between empty and full
    function automatic void make_request(output t_action a, output t_value v,
                                         output t_slot s);
        int unsigned roll;
        int unsigned used;
        used = used_count();
        if (fill_mode && used == SLOTS - 1)
            fill_mode = 1'b0;
        else if (!fill_mode && used == 0)
            fill_mode = 1'b1;
        roll = $urandom_range(99);
        if (roll < 4)
            v = '0;
        else if (roll < 55)
            v = t_value'($urandom_range(8, 1));
        else
            v = t_value'($urandom_range(16'hFFFF));
        s    = t_slot'($urandom_range(SLOTS - 1));
        a    = t_action'($urandom_range(3));
        roll = $urandom_range(99);
        // about one word in twelve stays pure noise
        if (roll >= 8) begin
            roll = $urandom_range(99);
            if (fill_mode)
                a = (roll < 40) ? ACT_APPEND : (roll < 65) ? ACT_INSERT :
                    (roll < 75) ? ACT_REMOVE : ACT_FIND;
            else
                a = (roll < 55) ? ACT_REMOVE : (roll < 65) ? ACT_APPEND :
                    (roll < 75) ? ACT_INSERT : ACT_FIND;
            case (a)
                ACT_INSERT: if ($urandom_range(3) != 0) s = pick_used(1'b1);
                ACT_REMOVE: if (used > 0 && $urandom_range(4) != 0) s = pick_used(1'b0);
                ACT_FIND:   if (used > 0 && $urandom_range(1) != 0)
                                v = list_val[pick_used(1'b0)];
                default: ;
            endcase
        end
    endfunction

    // Offer one request word and log its expected answer on acceptance
    task automatic send_request(t_action a, t_value v, t_slot s, bit typed,
                                t_result typed_res);
        t_result r;
        while (src_pct != 0 && $urandom_range(99) < src_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.action <= a;
        req_if.value  <= v;
        req_if.slot   <= s;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        r = list_predict(a, v, s);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Result side: check each word, then choose ready for the next cycle
    initial begin
        t_result     want;
        int unsigned hold_left;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result word with nothing outstanding: slot %0d status %0d",
                           rsp_if.result_slot, rsp_if.status);
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (rsp_if.result_slot !== want.slot) begin
                        $error("result_slot: expected %0d, got %0d",
                               want.slot, rsp_if.result_slot);
                        err_count++;
                    end
                    if (rsp_if.status !== want.st) begin
                        $error("status: expected %0d, got %0d", want.st, rsp_if.status);
                        err_count++;
                    end
                end
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= !(snk_pct != 0 && $urandom_range(99) < snk_pct);
            end
        end
    end

    // Watchdog on cycles without any accepted word
    initial begin
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        t_action a;
        t_value  v;
        t_slot   s;
        t_result typed_res;
        t_idle   mode;
        i_rst_n       <= 1'b0;
        req_if.valid  <= 1'b0;
        req_if.action <= ACT_APPEND;
        req_if.value  <= '0;
        req_if.slot   <= '0;
        list_clear();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        foreach (directed_rows[k]) begin
            typed_res.slot = directed_rows[k].exp_slot;
            typed_res.st   = directed_rows[k].exp_st;
            repeat (directed_rows[k].reps)
                send_request(directed_rows[k].act, directed_rows[k].value,
                             directed_rows[k].slot, directed_rows[k].typed, typed_res);
        end
        req_if.valid <= 1'b0;
        wait_drained();

        // random phases, each with its own idling pattern
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: mode = IDLE_NONE;
                1: mode = (ph < 4) ? IDLE_SRC : IDLE_BOTH;
                2: mode = (ph < 4) ? IDLE_SNK : IDLE_SRC;
                default: mode = (ph < 4) ? IDLE_BOTH : IDLE_SNK;
            endcase
            src_pct = (mode == IDLE_SRC) ? 49 : (mode == IDLE_BOTH) ? 28 : 0;
            snk_pct = (mode == IDLE_SNK) ? 49 : (mode == IDLE_BOTH) ? 28 : 0;
            // long back-pressure while words keep coming
            if (ph == 0)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                make_request(a, v, s);
                send_request(a, v, s, 1'b0, '0);
            end
            req_if.valid <= 1'b0;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
